FILE: rtl/kdlp_pkg.sv
// ----------------------------------------------------------------------------
// kdlp_pkg
// Types and codes shared by the key debounce and long-press block.
// ----------------------------------------------------------------------------
package kdlp_pkg;

   // keys whose index counts as a pressed key; higher indexes read as no key
   localparam int KEY_COUNT = 2;

   localparam int CFG_WIDTH = 16;

   // register map, byte address = 4 * index
   localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
   localparam logic [1:0] REG_LONG_PRESS = 2'd1;
   localparam logic [1:0] REG_REPEAT     = 2'd2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd20;
   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] REPEAT_RESET     = 16'd200;

   // event codes
   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_PRESS      = 3'd1;
   localparam logic [2:0] EV_SHORT_REL  = 3'd2;
   localparam logic [2:0] EV_LONG_START = 3'd3;
   localparam logic [2:0] EV_LONG_HOLD  = 3'd4;
   localparam logic [2:0] EV_LONG_REL   = 3'd5;

   typedef struct packed {
      logic key_down;
      logic key_index;
   } req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic       event_key;
   } rsp_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ticks;
      logic [CFG_WIDTH-1:0] long_press_ticks;
      logic [CFG_WIDTH-1:0] repeat_ticks;
   } cfg_type;

endpackage

FILE: rtl/kdlp_csr.sv
// ----------------------------------------------------------------------------
// kdlp_csr
// APB-style register file holding the debounce, long-press and repeat periods.
// ----------------------------------------------------------------------------
module kdlp_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [3:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready,
   output kdlp_pkg::cfg_type        cfg
);
   import kdlp_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= LONG_PRESS_RESET;
         cfg_ff.repeat_ticks     <= REPEAT_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            REG_DEBOUNCE:   cfg_ff.debounce_ticks   <= csr_pwdata[CFG_WIDTH-1:0];
            REG_LONG_PRESS: cfg_ff.long_press_ticks <= csr_pwdata[CFG_WIDTH-1:0];
            REG_REPEAT:     cfg_ff.repeat_ticks     <= csr_pwdata[CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_DEBOUNCE:   csr_prdata = {16'd0, cfg_ff.debounce_ticks};
         REG_LONG_PRESS: csr_prdata = {16'd0, cfg_ff.long_press_ticks};
         REG_REPEAT:     csr_prdata = {16'd0, cfg_ff.repeat_ticks};
         default:        csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/kdlp_fsm.sv
// ----------------------------------------------------------------------------
// kdlp_fsm
// Key tracking state machine with tick counter and registered event output.
// ----------------------------------------------------------------------------
module kdlp_fsm #(
   parameter int TICK_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  kdlp_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  kdlp_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output kdlp_pkg::rsp_type   rsp_data
);
   import kdlp_pkg::*;

   localparam int CMP_WIDTH = (TICK_WIDTH > CFG_WIDTH) ? TICK_WIDTH : CFG_WIDTH;

   localparam logic [1:0] PH_IDLE     = 2'd0;
   localparam logic [1:0] PH_DEBOUNCE = 2'd1;
   localparam logic [1:0] PH_PRESSED  = 2'd2;
   localparam logic [1:0] PH_LONG     = 2'd3;

   logic [1:0]            phase_ff, phase_in;
   logic                  held_key_ff, held_key_in;
   logic [TICK_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic                  present;
   logic                  match;
   logic                  expired;
   logic [TICK_WIDTH-1:0] elapsed_inc;
   logic [CFG_WIDTH-1:0]  limit;
   logic [2:0]            ev;
   logic                  ev_key;

   // the result register frees up whenever its transfer completes
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign present = req_data.key_down && (32'(req_data.key_index) < KEY_COUNT);
   assign match   = present && (req_data.key_index == held_key_ff);

   // saturate at all ones
   assign elapsed_inc = (&elapsed_ff) ? elapsed_ff : elapsed_ff + 1'b1;

   always_comb begin
      case (phase_ff)
         PH_DEBOUNCE: limit = cfg.debounce_ticks;
         PH_PRESSED:  limit = cfg.long_press_ticks;
         default:     limit = cfg.repeat_ticks;
      endcase
   end

   assign expired = CMP_WIDTH'(elapsed_inc) >= CMP_WIDTH'(limit);

   always_comb begin
      phase_in    = phase_ff;
      held_key_in = held_key_ff;
      elapsed_in  = elapsed_ff;
      ev          = EV_NONE;
      ev_key      = held_key_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (present) begin
               held_key_in = req_data.key_index;
               ev_key      = req_data.key_index;
               elapsed_in  = '0;
               phase_in    = PH_DEBOUNCE;
               // zero debounce period: press at the capture tick
               if (cfg.debounce_ticks == '0) begin
                  phase_in = PH_PRESSED;
                  ev       = EV_PRESS;
               end
            end
         end
         PH_DEBOUNCE: begin
            if (!match) begin
               phase_in = PH_IDLE;
            end else if (expired) begin
               elapsed_in = '0;
               phase_in   = PH_PRESSED;
               ev         = EV_PRESS;
            end else begin
               elapsed_in = elapsed_inc;
            end
         end
         PH_PRESSED: begin
            if (!match) begin
               phase_in = PH_IDLE;
               ev       = EV_SHORT_REL;
            end else if (expired) begin
               elapsed_in = '0;
               phase_in   = PH_LONG;
               ev         = EV_LONG_START;
            end else begin
               elapsed_in = elapsed_inc;
            end
         end
         default: begin
            if (!match) begin
               phase_in = PH_IDLE;
               ev       = EV_LONG_REL;
            end else if (expired) begin
               elapsed_in = '0;
               ev         = EV_LONG_HOLD;
            end else begin
               elapsed_in = elapsed_inc;
            end
         end
      endcase
   end

   always_comb begin
      rsp_in.event_res = ev;
      rsp_in.event_key = (ev == EV_NONE) ? 1'b0 : ev_key;
   end

   assign rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         held_key_ff  <= 1'b0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff    <= phase_in;
            held_key_ff <= held_key_in;
            elapsed_ff  <= elapsed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idle_state_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase_ff) && $stable(elapsed_ff) && $stable(held_key_ff))
      else $error("state moved without an input transfer");

   a_press_enters_pressed: assert property (@(posedge clock) disable iff (reset)
      accept && (ev == EV_PRESS) |=> (phase_ff == PH_PRESSED) && (elapsed_ff == '0))
      else $error("press event without entering pressed phase");

   a_release_to_idle: assert property (@(posedge clock) disable iff (reset)
      accept && ((ev == EV_SHORT_REL) || (ev == EV_LONG_REL)) |=> (phase_ff == PH_IDLE))
      else $error("release event without return to idle");

   a_hold_only_in_long: assert property (@(posedge clock) disable iff (reset)
      accept && (ev == EV_LONG_HOLD) |-> (phase_ff == PH_LONG))
      else $error("repeat event outside long phase");

   a_no_event_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.event_res == EV_NONE) |-> (rsp_ff.event_key == 1'b0))
      else $error("key reported without an event");

endmodule

FILE: rtl/key_debounce_long_press.sv
// ----------------------------------------------------------------------------
// key_debounce_long_press
// Debounced key events with press, short release, long press and repeat.
// ----------------------------------------------------------------------------
// Event output: the event for a tick appears in the result register the
//   cycle after the tick's transfer.
// Throughput: one tick per cycle, set by the single state update and result
//   register stage; the input stalls only while a result waits to be taken.
// Reset (synchronous): phase idle, counter cleared, no result pending, periods
//   back to 20, 1000 and 200 ticks.
module key_debounce_long_press #(
   parameter int TICK_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  kdlp_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output kdlp_pkg::rsp_type   rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import kdlp_pkg::*;

   cfg_type cfg;

   kdlp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kdlp_fsm #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: verif/key_debounce_long_press_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_debounce_long_press_tb
// Feeds key samples one tick per transfer and checks every event produced.
// A scoreboard tracks the debounce, press, long-press and repeat timing of the
// held key and compares each event and key index in order. Directed ticks
// cover zero periods, key changes and bounce. Random phases with small
// periods (reset ones first) follow, ending with all at maximum. Both sides idle
// at random.
// ----------------------------------------------------------------------------
module key_debounce_long_press_tb;
   import kdlp_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_TICKS  = 200;

   class tick_scoreboard;
      typedef enum logic [1:0] {PH_IDLE, PH_DEBOUNCE, PH_PRESSED, PH_LONG} key_phase_e;

      logic [CFG_WIDTH-1:0] debounce_ticks   = DEBOUNCE_RESET;
      logic [CFG_WIDTH-1:0] long_press_ticks = LONG_PRESS_RESET;
      logic [CFG_WIDTH-1:0] repeat_ticks     = REPEAT_RESET;

      key_phase_e           phase    = PH_IDLE;
      logic                 held_key = 1'b0;
      logic [CFG_WIDTH-1:0] elapsed  = '0;

      rsp_type expected_events[$];
      int      errors;
      int      events_seen[8];

      function void set_reg(logic [1:0] idx, logic [CFG_WIDTH-1:0] value);
         case (idx)
            REG_DEBOUNCE:   debounce_ticks   = value;
            REG_LONG_PRESS: long_press_ticks = value;
            REG_REPEAT:     repeat_ticks     = value;
            default: ;
         endcase
      endfunction

      function logic [CFG_WIDTH-1:0] get_reg(logic [1:0] idx);
         case (idx)
            REG_DEBOUNCE:   return debounce_ticks;
            REG_LONG_PRESS: return long_press_ticks;
            default:        return repeat_ticks;
         endcase
      endfunction

      // count one matching tick, saturating, and report whether the period is over
      function bit period_over(logic [CFG_WIDTH-1:0] limit);
         if (elapsed != '1) elapsed = elapsed + 1'b1;
         return elapsed >= limit;
      endfunction

      function void note_tick(req_type sample);
         rsp_type ev;
         logic    present;
         logic    same_key;
         ev.event_res = EV_NONE;
         ev.event_key = 1'b0;
         present  = sample.key_down && (int'(sample.key_index) < KEY_COUNT);
         same_key = present && (sample.key_index == held_key);
         case (phase)
            PH_IDLE: begin
               if (present) begin
                  held_key = sample.key_index;
                  elapsed  = '0;
                  phase    = PH_DEBOUNCE;
                  // a zero debounce period presses on the capture tick
                  if (debounce_ticks == '0) begin
                     phase        = PH_PRESSED;
                     ev.event_res = EV_PRESS;
                     ev.event_key = held_key;
                  end
               end
            end
            PH_DEBOUNCE: begin
               if (!same_key) begin
                  phase = PH_IDLE;
               end else if (period_over(debounce_ticks)) begin
                  elapsed      = '0;
                  phase        = PH_PRESSED;
                  ev.event_res = EV_PRESS;
                  ev.event_key = held_key;
               end
            end
            PH_PRESSED: begin
               if (!same_key) begin
                  phase        = PH_IDLE;
                  ev.event_res = EV_SHORT_REL;
                  ev.event_key = held_key;
               end else if (period_over(long_press_ticks)) begin
                  elapsed      = '0;
                  phase        = PH_LONG;
                  ev.event_res = EV_LONG_START;
                  ev.event_key = held_key;
               end
            end
            default: begin
               if (!same_key) begin
                  phase        = PH_IDLE;
                  ev.event_res = EV_LONG_REL;
                  ev.event_key = held_key;
               end else if (period_over(repeat_ticks)) begin
                  elapsed      = '0;
                  ev.event_res = EV_LONG_HOLD;
                  ev.event_key = held_key;
               end
            end
         endcase
         expected_events.push_back(ev);
      endfunction

      function void check_event(rsp_type got);
         rsp_type want;
         if (expected_events.size() == 0) begin
            $error("event transfer with nothing outstanding: event_res %0d event_key %0d",
                   got.event_res, got.event_key);
            errors++;
            return;
         end
         want = expected_events.pop_front();
         if (got.event_res !== want.event_res) begin
            $error("event_res: expected %0d, actual %0d", want.event_res, got.event_res);
            errors++;
         end
         if (got.event_key !== want.event_key) begin
            $error("event_key: expected %0d, actual %0d", want.event_key, got.event_key);
            errors++;
         end
         if (got.event_res === want.event_res) events_seen[want.event_res]++;
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tick_scoreboard sb;
   bit             quiet;
   int             stall_left;
   int             cycle_count;
   int             ticks_sent;
   int             settings_used;

   key_debounce_long_press u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_event(rsp_data);
   end

   task automatic csr_access(input logic wr, input logic [1:0] idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (wr) sb.set_reg(idx, wdata[CFG_WIDTH-1:0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_reg(input logic [1:0] idx);
      logic [31:0] rdata;
      csr_access(1'b0, idx, '0, rdata);
      if (rdata !== {16'b0, sb.get_reg(idx)}) begin
         $error("csr_prdata[%0d]: expected %0d, actual %0d", idx, sb.get_reg(idx), rdata);
         sb.errors++;
      end
   endtask

   task automatic set_periods(input logic [CFG_WIDTH-1:0] debounce,
                              input logic [CFG_WIDTH-1:0] long_press,
                              input logic [CFG_WIDTH-1:0] repeat_period);
      logic [31:0] unused;
      csr_access(1'b1, REG_DEBOUNCE, {16'b0, debounce}, unused);
      csr_access(1'b1, REG_LONG_PRESS, {16'b0, long_press}, unused);
      csr_access(1'b1, REG_REPEAT, {16'b0, repeat_period}, unused);
      check_reg(REG_DEBOUNCE);
      check_reg(REG_LONG_PRESS);
      check_reg(REG_REPEAT);
      settings_used++;
   endtask

   task automatic send_tick(input logic down, input logic idx);
      req_type sample;
      int      gap;
      sample.key_down  = down;
      sample.key_index = idx;
      req_valid <= 1'b1;
      req_data  <= sample;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_tick(sample);
      ticks_sent++;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off the sender until every outstanding event has been taken
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_events.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic key_hold(input logic idx, input int hold, input int released);
      repeat (hold) send_tick(1'b1, idx);
      repeat (released) send_tick(1'b0, 1'($urandom_range(0, 1)));
   endtask

   task automatic random_phase(input int n_ticks);
      int stop_at;
      int span;
      int bounce;
      stop_at = ticks_sent + n_ticks;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(0, 9) < 8) begin
            span = int'(sb.debounce_ticks) + int'(sb.long_press_ticks)
                   + 3 * int'(sb.repeat_ticks) + 6;
            if (span > 60) span = 60;
            bounce = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            repeat (bounce) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            key_hold(1'($urandom_range(0, 1)), $urandom_range(0, span), $urandom_range(0, 3));
         end else begin
            repeat ($urandom_range(1, 5))
               send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      sb = new;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_reg(REG_DEBOUNCE);
      check_reg(REG_LONG_PRESS);
      check_reg(REG_REPEAT);

      // zero periods: press on capture, long start and repeat on each next tick
      set_periods(16'd0, 16'd0, 16'd0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      drain();

      // key change during debounce drops silently; then a full long press
      set_periods(16'd2, 16'd3, 16'd1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      repeat (7) send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      drain();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_periods(DEBOUNCE_RESET, LONG_PRESS_RESET, REPEAT_RESET);
            1: set_periods(16'd1, 16'd1, 16'd1);
            2: set_periods(16'd0, 16'($urandom_range(0, 15)), 16'd0);
            default: set_periods(16'($urandom_range(0, 6)), 16'($urandom_range(0, 15)),
                                 16'($urandom_range(0, 5)));
         endcase
         quiet = (p == 5);
         if (p == 3) begin
            random_phase(PHASE_TICKS / 2);
            drain();
            random_phase(PHASE_TICKS / 2);
         end else begin
            random_phase(PHASE_TICKS);
         end
         drain();
      end

      // maximum periods, no idling: a long hold stays silent short of the debounce period
      quiet = 1'b1;
      set_periods(16'hFFFF, 16'hFFFF, 16'hFFFF);
      key_hold(1'b1, 100, 1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      drain();
      repeat (8) @(posedge clock);

      $display("summary: %0d ticks over %0d period settings, zero and maximum periods included",
               ticks_sent, settings_used);
      $display("summary: %0d press, %0d short release, %0d long start, %0d hold, %0d long release",
               sb.events_seen[EV_PRESS], sb.events_seen[EV_SHORT_REL],
               sb.events_seen[EV_LONG_START], sb.events_seen[EV_LONG_HOLD],
               sb.events_seen[EV_LONG_REL]);
      if (sb.errors == 0 && sb.expected_events.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
